// ----- src/gcts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcts_pkg
// Shared widths, beat types and register codes of the ground contact time
// solver.
// ----------------------------------------------------------------------------
package gcts_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int EPS_BITS  = 16;
	localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(7);

	// radicand V^2 - 2*A*Y0 and its root
	localparam int DISC_BITS = 2 * WORD_BITS + 3;
	localparam int ROOT_BITS = (DISC_BITS + 1) / 2;
	// magnitude of -V +/- S, and of the shifted dividend
	localparam int NUM_BITS  = WORD_BITS + 3;
	localparam int QUO_BITS  = NUM_BITS + FRAC_BITS;

	// register port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic [APB_ADDR_BITS-3:0] REG_EPSILON = '0;

	typedef struct packed {
		logic                        exit_kind;
		logic signed [WORD_BITS-1:0] exit_value;
		logic signed [WORD_BITS-1:0] activation_time;
		logic signed [WORD_BITS-1:0] position_y;
		logic signed [WORD_BITS-1:0] velocity_y;
		logic signed [WORD_BITS-1:0] acceleration_y;
		logic signed [WORD_BITS-1:0] motion_start;
	} item_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] exit_time;
		logic                        never_hits;
		logic                        saturated;
	} result_t;

	// control and operands that ride along the square root
	typedef struct packed {
		logic                        kind;
		logic                        never;
		logic                        linear;
		logic                        a_neg;
		logic signed [WORD_BITS-1:0] base;
		logic signed [WORD_BITS-1:0] off;
		logic signed [WORD_BITS-1:0] v;
		logic signed [WORD_BITS:0]   y0;
		logic [WORD_BITS-1:0]        dvsr;
	} sq_side_t;

	// control that rides along the divider
	typedef struct packed {
		logic                        kind;
		logic                        never;
		logic                        linear;
		logic                        neg0;
		logic                        neg1;
		logic signed [WORD_BITS-1:0] base;
		logic signed [WORD_BITS-1:0] off;
	} dv_side_t;

endpackage
`default_nettype wire

// ----- src/gcts_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcts_front
// Three stage front end: offsets and magnitudes, the two wide products, and
// the discriminant with its sign test.
// ----------------------------------------------------------------------------
module gcts_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               in_valid,
	input  wire gcts_pkg::item_t                    item,
	input  wire logic [gcts_pkg::EPS_BITS-1:0]      eps,
	output logic                                    valid,
	output logic [gcts_pkg::DISC_BITS-1:0]          disc,
	output gcts_pkg::sq_side_t                      side
);
	localparam int W  = gcts_pkg::WORD_BITS;
	localparam int DB = gcts_pkg::DISC_BITS;

	logic [W-1:0]        eps_w;
	logic signed [W:0]   y0_c;
	logic [W-1:0]        am_c, vm_c;
	logic                linear_c, stat_c;

	logic                valid_s1, kind_s1, a_neg_s1, linear_s1, never_s1;
	logic signed [W-1:0] base_s1, off_s1, v_s1;
	logic signed [W:0]   y0_s1;
	logic [W-1:0]        am_s1, vm_s1;

	logic [W:0]          y0m_c;
	logic [W+1:0]        y2m_c;
	logic                prod_neg_c;

	logic                valid_s2, kind_s2, a_neg_s2, linear_s2, never_s2, prod_neg_s2;
	logic signed [W-1:0] base_s2, off_s2, v_s2;
	logic signed [W:0]   y0_s2;
	logic [W-1:0]        dvsr_s2;
	logic [2*W-1:0]      v2_s2;
	logic [2*W+1:0]      p_s2;

	logic [DB-1:0]       v2e_c, pe_c, d_c;
	logic                negdisc_c;

	logic                valid_s3;
	logic [DB-1:0]       disc_s3;
	gcts_pkg::sq_side_t  side_s3;

	// take offsets and magnitudes
	always_comb begin
		eps_w    = {{(W-gcts_pkg::EPS_BITS){1'b0}}, eps};
		y0_c     = {item.position_y[W-1], item.position_y}
		         - {item.exit_value[W-1], item.exit_value};
		am_c     = item.acceleration_y[W-1] ? (~item.acceleration_y + 1'b1)
		                                    : item.acceleration_y;
		vm_c     = item.velocity_y[W-1] ? (~item.velocity_y + 1'b1) : item.velocity_y;
		linear_c = (am_c < eps_w) || (am_c == '0);
		stat_c   = (vm_c < eps_w) || (vm_c == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= item.exit_kind;
			base_s1   <= item.exit_kind ? item.motion_start : item.activation_time;
			off_s1    <= item.exit_value;
			v_s1      <= item.velocity_y;
			a_neg_s1  <= item.acceleration_y[W-1];
			y0_s1     <= y0_c;
			am_s1     <= am_c;
			vm_s1     <= vm_c;
			linear_s1 <= linear_c;
			never_s1  <= item.exit_kind && linear_c && stat_c;
		end
	end

	// form V^2 and 2|A||Y0|
	always_comb begin
		y0m_c      = y0_s1[W] ? (~y0_s1 + 1'b1) : y0_s1;
		y2m_c      = {y0m_c, 1'b0};
		prod_neg_c = (y0_s1 != '0) && (a_neg_s1 != y0_s1[W]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v2_s2       <= vm_s1 * vm_s1;
			p_s2        <= (2*W+2)'(am_s1) * y2m_c;
			prod_neg_s2 <= prod_neg_c;
			kind_s2     <= kind_s1;
			base_s2     <= base_s1;
			off_s2      <= off_s1;
			v_s2        <= v_s1;
			a_neg_s2    <= a_neg_s1;
			y0_s2       <= y0_s1;
			linear_s2   <= linear_s1;
			never_s2    <= never_s1;
			dvsr_s2     <= linear_s1 ? vm_s1 : am_s1;
		end
	end

	// combine into the discriminant, flag a negative one
	always_comb begin
		v2e_c     = DB'(v2_s2);
		pe_c      = DB'(p_s2);
		d_c       = prod_neg_s2 ? (v2e_c + pe_c) : (v2e_c - pe_c);
		negdisc_c = !prod_neg_s2 && (v2e_c < pe_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s3        <= d_c;
			side_s3.kind   <= kind_s2;
			side_s3.never  <= never_s2 || (kind_s2 && !linear_s2 && negdisc_c);
			side_s3.linear <= linear_s2;
			side_s3.a_neg  <= a_neg_s2;
			side_s3.base   <= base_s2;
			side_s3.off    <= off_s2;
			side_s3.v      <= v_s2;
			side_s3.y0     <= y0_s2;
			side_s3.dvsr   <= dvsr_s2;
		end
	end

	assign valid = valid_s3;
	assign disc  = disc_s3;
	assign side  = side_s3;

endmodule
`default_nettype wire

// ----- src/gcts_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcts_sqrt
// Pipelined integer square root, one root bit per stage, with a side
// payload that travels alongside.
// ----------------------------------------------------------------------------
module gcts_sqrt #(
	parameter int ROOT_BITS = 34,
	parameter int SIDE_BITS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic [2*ROOT_BITS-1:0] radicand,
	input  wire logic [SIDE_BITS-1:0]   in_side,
	output logic                        valid,
	output logic [ROOT_BITS-1:0]        root,
	output logic [SIDE_BITS-1:0]        side
);
	localparam int R = ROOT_BITS;

	logic                 valid_s [R];
	logic [2*R-1:0]       work_s  [R];
	logic [R-1:0]         root_s  [R];
	logic [R+1:0]         rem_s   [R];
	logic [SIDE_BITS-1:0] side_s  [R];

	for (genvar g = 0; g < R; g++) begin : g_stage
		logic                 cur_valid;
		logic [2*R-1:0]       cur_work;
		logic [R-1:0]         cur_root;
		logic [R+1:0]         cur_rem;
		logic [SIDE_BITS-1:0] cur_side;
		logic [R+3:0]         shifted, trial;
		logic                 ge;

		if (g == 0) begin : g_head
			assign cur_valid = in_valid;
			assign cur_work  = radicand;
			assign cur_root  = '0;
			assign cur_rem   = '0;
			assign cur_side  = in_side;
		end else begin : g_body
			assign cur_valid = valid_s[g-1];
			assign cur_work  = work_s[g-1];
			assign cur_root  = root_s[g-1];
			assign cur_rem   = rem_s[g-1];
			assign cur_side  = side_s[g-1];
		end

		// try the next root bit against the two incoming radicand bits
		always_comb begin
			shifted = {cur_rem, cur_work[2*R-1 -: 2]};
			trial   = {2'b00, cur_root, 2'b01};
			ge      = (shifted >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (en) begin
				valid_s[g] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? (R+2)'(shifted - trial) : (R+2)'(shifted);
				root_s[g] <= {cur_root[R-2:0], ge};
				work_s[g] <= {cur_work[2*R-3:0], 2'b00};
				side_s[g] <= cur_side;
			end
		end
	end

	assign valid = valid_s[R-1];
	assign root  = root_s[R-1];
	assign side  = side_s[R-1];

endmodule
`default_nettype wire

// ----- src/gcts_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcts_div
// Pipelined restoring divider with two lanes over one shared divisor, one
// quotient bit per stage, and a side payload alongside.
// ----------------------------------------------------------------------------
module gcts_div #(
	parameter int QUO_BITS  = 51,
	parameter int DVSR_BITS = 32,
	parameter int SIDE_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [QUO_BITS-1:0]  num0,
	input  wire logic [QUO_BITS-1:0]  num1,
	input  wire logic [DVSR_BITS-1:0] dvsr,
	input  wire logic [SIDE_BITS-1:0] in_side,
	output logic                      valid,
	output logic [QUO_BITS-1:0]       quo0,
	output logic [QUO_BITS-1:0]       quo1,
	output logic [SIDE_BITS-1:0]      side
);
	localparam int Q = QUO_BITS;
	localparam int D = DVSR_BITS;

	logic                 valid_s [Q];
	logic [Q-1:0]         work0_s [Q];
	logic [Q-1:0]         work1_s [Q];
	logic [D-1:0]         rem0_s  [Q];
	logic [D-1:0]         rem1_s  [Q];
	logic [D-1:0]         dvsr_s  [Q];
	logic [SIDE_BITS-1:0] side_s  [Q];

	for (genvar g = 0; g < Q; g++) begin : g_stage
		logic                 cur_valid;
		logic [Q-1:0]         cur_work0, cur_work1;
		logic [D-1:0]         cur_rem0, cur_rem1, cur_dvsr;
		logic [SIDE_BITS-1:0] cur_side;
		logic [D:0]           sh0, sh1;
		logic                 ge0, ge1;

		if (g == 0) begin : g_head
			assign cur_valid = in_valid;
			assign cur_work0 = num0;
			assign cur_work1 = num1;
			assign cur_rem0  = '0;
			assign cur_rem1  = '0;
			assign cur_dvsr  = dvsr;
			assign cur_side  = in_side;
		end else begin : g_body
			assign cur_valid = valid_s[g-1];
			assign cur_work0 = work0_s[g-1];
			assign cur_work1 = work1_s[g-1];
			assign cur_rem0  = rem0_s[g-1];
			assign cur_rem1  = rem1_s[g-1];
			assign cur_dvsr  = dvsr_s[g-1];
			assign cur_side  = side_s[g-1];
		end

		// shift in the next dividend bit, subtract where it fits
		always_comb begin
			sh0 = {cur_rem0, cur_work0[Q-1]};
			sh1 = {cur_rem1, cur_work1[Q-1]};
			ge0 = (sh0 >= {1'b0, cur_dvsr});
			ge1 = (sh1 >= {1'b0, cur_dvsr});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (en) begin
				valid_s[g] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem0_s[g]  <= ge0 ? D'(sh0 - {1'b0, cur_dvsr}) : D'(sh0);
				rem1_s[g]  <= ge1 ? D'(sh1 - {1'b0, cur_dvsr}) : D'(sh1);
				work0_s[g] <= {cur_work0[Q-2:0], ge0};
				work1_s[g] <= {cur_work1[Q-2:0], ge1};
				dvsr_s[g]  <= cur_dvsr;
				side_s[g]  <= cur_side;
			end
		end
	end

	assign valid = valid_s[Q-1];
	assign quo0  = work0_s[Q-1];
	assign quo1  = work1_s[Q-1];
	assign side  = side_s[Q-1];

endmodule
`default_nettype wire

// ----- src/ground_contact_time_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ground_contact_time_solver
// Exit time of one motion phase: a fixed time offset or the time of ground
// contact under constant vertical acceleration, in signed Q16.16.
// ----------------------------------------------------------------------------
// Input beats arrive on item_valid / item_stall / item, results leave on
// result_valid / result_stall / result. A beat moves at a clock edge where
// valid is high and stall is low. Every input beat yields one result beat,
// in order.
// The pipeline has three front stages for offsets, products and the
// discriminant, one stage per root bit in the square root, one numerator
// stage, one stage per quotient bit in the two-lane divider, a root pick
// stage and the output register. Throughput is one beat per cycle; the
// pipeline takes a new beat every cycle while the output register is free
// or being emptied. When the receiver stalls a full output register, the
// whole pipeline holds and item_stall rises in the same cycle; nothing is
// dropped or repeated. Reset clears all valid bits and sets epsilon to 7.
// Epsilon is written over the register port at byte address 0; the user
// must write it only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module ground_contact_time_solver (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire gcts_pkg::item_t                      item,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output gcts_pkg::result_t                         result,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [gcts_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire logic [gcts_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [gcts_pkg::APB_DATA_BITS-1:0]        prdata,
	output logic                                      pready
);
	localparam int W   = gcts_pkg::WORD_BITS;
	localparam int F   = gcts_pkg::FRAC_BITS;
	localparam int R   = gcts_pkg::ROOT_BITS;
	localparam int NB  = gcts_pkg::NUM_BITS;
	localparam int QB  = gcts_pkg::QUO_BITS;
	localparam int EB  = gcts_pkg::EPS_BITS;
	localparam int AB  = gcts_pkg::APB_ADDR_BITS;
	localparam int DTB = gcts_pkg::APB_DATA_BITS;
	localparam int SQ_SIDE_BITS = $bits(gcts_pkg::sq_side_t);
	localparam int DV_SIDE_BITS = $bits(gcts_pkg::dv_side_t);
	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

	logic                en;
	logic [EB-1:0]       eps_q;
	logic                cfg_wr;
	logic [W-1:0]        eps_w;

	logic                fr_valid;
	logic [gcts_pkg::DISC_BITS-1:0] fr_disc;
	gcts_pkg::sq_side_t  fr_side;

	logic                sq_valid;
	logic [R-1:0]        sq_root;
	logic [SQ_SIDE_BITS-1:0] sq_side_raw;
	gcts_pkg::sq_side_t  sq_side;

	logic signed [NB:0]  nv_c, re_c, n0_c, n1_c;
	logic [NB-1:0]       mag0_c, mag1_c, y0m_c;
	logic                y0_pos_c;

	logic                valid_s4;
	logic [QB-1:0]       num0_s4, num1_s4;
	logic [W-1:0]        dvsr_s4;
	gcts_pkg::dv_side_t  side_s4;

	logic                dv_valid;
	logic [QB-1:0]       quo0, quo1;
	logic [DV_SIDE_BITS-1:0] dv_side_raw;
	gcts_pkg::dv_side_t  dv_side;

	logic [W:0]          cl0_c, cl1_c;
	logic                ok0_c, ok1_c, pick1_c, found_c;
	logic [W-1:0]        best_c;
	logic                best_sat_c;

	logic                valid_s5, kind_s5, never_s5, sat_s5;
	logic signed [W-1:0] base_s5, add_s5;

	logic signed [W:0]   sum_c;
	gcts_pkg::result_t   res_c;

	logic                result_valid_q;
	gcts_pkg::result_t   result_q;

	// magnitude of a signed numerator
	function automatic logic [NB-1:0] num_mag(input logic signed [NB:0] n);
		logic [NB:0] m;
		m = n[NB] ? (~n + 1'b1) : n;
		return m[NB-1:0];
	endfunction

	// clamp an unsigned quotient with its sign into the word range
	function automatic logic [W:0] clamp_q(input logic [QB-1:0] q, input logic neg);
		logic [W:0] r;
		if (neg) begin
			if (q > {{(QB-W){1'b0}}, WMIN}) r = {1'b1, WMIN};
			else                            r = {1'b0, ~q[W-1:0] + 1'b1};
		end else begin
			if (q > {{(QB-W){1'b0}}, WMAX}) r = {1'b1, WMAX};
			else                            r = {1'b0, q[W-1:0]};
		end
		return r;
	endfunction

	// whole pipeline moves unless a finished result is stalled
	assign en         = !(result_valid_q && result_stall);
	assign item_stall = !en;

	// register port
	assign cfg_wr = psel && penable && pwrite && (paddr[AB-1:2] == gcts_pkg::REG_EPSILON);
	assign pready = 1'b1;
	assign prdata = (paddr[AB-1:2] == gcts_pkg::REG_EPSILON)
	              ? {{(DTB-EB){1'b0}}, eps_q} : '0;
	assign eps_w  = {{(W-EB){1'b0}}, eps_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= gcts_pkg::EPS_RESET;
		end else if (cfg_wr) begin
			eps_q <= pwdata[EB-1:0];
		end
	end

	gcts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (item_valid),
		.item     (item),
		.eps      (eps_q),
		.valid    (fr_valid),
		.disc     (fr_disc),
		.side     (fr_side)
	);

	gcts_sqrt #(
		.ROOT_BITS (R),
		.SIDE_BITS (SQ_SIDE_BITS)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.radicand ((2*R)'(fr_disc)),
		.in_side  (fr_side),
		.valid    (sq_valid),
		.root     (sq_root),
		.side     (sq_side_raw)
	);

	assign sq_side = gcts_pkg::sq_side_t'(sq_side_raw);

	// build -V + S and -V - S, or -Y0 for the linear case
	always_comb begin
		nv_c     = -{{(NB+1-W){sq_side.v[W-1]}}, sq_side.v};
		re_c     = {{(NB+1-R){1'b0}}, sq_root};
		n0_c     = nv_c + re_c;
		n1_c     = nv_c - re_c;
		y0m_c    = num_mag({{(NB-W){sq_side.y0[W]}}, sq_side.y0});
		y0_pos_c = !sq_side.y0[W] && (sq_side.y0 != '0);
		mag0_c   = sq_side.linear ? y0m_c : num_mag(n0_c);
		mag1_c   = num_mag(n1_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num0_s4        <= {mag0_c, {F{1'b0}}};
			num1_s4        <= {mag1_c, {F{1'b0}}};
			dvsr_s4        <= sq_side.dvsr;
			side_s4.kind   <= sq_side.kind;
			side_s4.never  <= sq_side.never;
			side_s4.linear <= sq_side.linear;
			side_s4.neg0   <= sq_side.linear ? (y0_pos_c != sq_side.v[W-1])
			                                 : (n0_c[NB] != sq_side.a_neg);
			side_s4.neg1   <= n1_c[NB] != sq_side.a_neg;
			side_s4.base   <= sq_side.base;
			side_s4.off    <= sq_side.off;
		end
	end

	gcts_div #(
		.QUO_BITS  (QB),
		.DVSR_BITS (W),
		.SIDE_BITS (DV_SIDE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s4),
		.num0     (num0_s4),
		.num1     (num1_s4),
		.dvsr     (dvsr_s4),
		.in_side  (side_s4),
		.valid    (dv_valid),
		.quo0     (quo0),
		.quo1     (quo1),
		.side     (dv_side_raw)
	);

	assign dv_side = gcts_pkg::dv_side_t'(dv_side_raw);

	// clamp both roots, keep the smallest one above epsilon
	always_comb begin
		cl0_c      = clamp_q(quo0, dv_side.neg0);
		cl1_c      = clamp_q(quo1, dv_side.neg1);
		ok0_c      = $signed(cl0_c[W-1:0]) > $signed(eps_w);
		ok1_c      = !dv_side.linear && ($signed(cl1_c[W-1:0]) > $signed(eps_w));
		pick1_c    = ok1_c && (!ok0_c || ($signed(cl1_c[W-1:0]) < $signed(cl0_c[W-1:0])));
		found_c    = ok0_c || ok1_c;
		best_c     = pick1_c ? cl1_c[W-1:0] : cl0_c[W-1:0];
		best_sat_c = pick1_c ? cl1_c[W] : cl0_c[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5  <= dv_side.kind;
			never_s5 <= dv_side.never || (dv_side.kind && !found_c);
			base_s5  <= dv_side.base;
			add_s5   <= dv_side.kind ? $signed(best_c) : dv_side.off;
			sat_s5   <= dv_side.kind && best_sat_c;
		end
	end

	// saturating final sum
	always_comb begin
		sum_c = {base_s5[W-1], base_s5} + {add_s5[W-1], add_s5};
		res_c.never_hits = never_s5;
		case (sum_c[W:W-1])
			2'b01: begin
				res_c.exit_time = WMAX;
				res_c.saturated = 1'b1;
			end
			2'b10: begin
				res_c.exit_time = WMIN;
				res_c.saturated = 1'b1;
			end
			default: begin
				res_c.exit_time = sum_c[W-1:0];
				res_c.saturated = sat_s5;
			end
		endcase
		if (never_s5) begin
			res_c.exit_time = '0;
			res_c.saturated = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a never result carries no time and no clamp
	a_never_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.never_hits |->
			(result_q.exit_time == '0) && !result_q.saturated)
		else $error("never result with nonzero time or clamp");

	// time mode never reports a missing contact
	a_time_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !kind_s5 |-> !never_s5)
		else $error("time mode item flagged as never");

	// the linear case only ever uses lane 0
	a_linear_lane: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && dv_side.linear |-> !pick1_c)
		else $error("linear case picked the second root");

	// a stalled result stays in place for the next cycle
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> result_valid_q && $stable(result_q))
		else $error("stalled result beat changed");

endmodule
`default_nettype wire

// ----- sim/ground_contact_time_solver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ground_contact_time_solver_tb
// Drives time and ground contact beats with random gaps and stalls, predicts
// each exit time with exact wide integer math and compares every result beat
// in order. Epsilon is rewritten between phases, including its extremes.
// ----------------------------------------------------------------------------
module ground_contact_time_solver_tb;

	localparam int LATENCY     = 2 * gcts_pkg::WORD_BITS + gcts_pkg::FRAC_BITS + 11;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic KIND_TIME   = 1'b0;
	localparam logic KIND_GROUND = 1'b1;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	gcts_pkg::item_t item;
	logic result_valid;
	logic result_stall;
	gcts_pkg::result_t result;
	logic psel, penable, pwrite;
	logic [gcts_pkg::APB_ADDR_BITS-1:0] paddr;
	logic [gcts_pkg::APB_DATA_BITS-1:0] pwdata;
	logic [gcts_pkg::APB_DATA_BITS-1:0] prdata;
	logic pready;

	ground_contact_time_solver u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gcts_pkg::result_t exit_q[$];
	logic [15:0] eps_model;
	int mismatches;
	int cycles;
	bit hold_results;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle count and timeout
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// (n << FRAC_BITS) / d toward zero, clamped to the word range
	function automatic longint unsigned div_clamp(input logic signed [127:0] n,
			input logic signed [127:0] d, output bit sat);
		logic signed [127:0] q;
		q = (n <<< gcts_pkg::FRAC_BITS) / d;
		sat = 1'b0;
		if (q > 128'sd2147483647) begin
			sat = 1'b1;
			q = 128'sd2147483647;
		end else if (q < -128'sd2147483648) begin
			sat = 1'b1;
			q = -128'sd2147483648;
		end
		return q[63:0];
	endfunction

	function automatic logic signed [127:0] isqrt_floor(input logic signed [127:0] n);
		logic signed [127:0] r;
		logic signed [127:0] t;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (128'sd1 << i);
			if (t * t <= n) r = t;
		end
		return r;
	endfunction

	function automatic logic signed [127:0] clamp_sum(input logic signed [127:0] s,
			inout bit sat);
		if (s > 128'sd2147483647) begin
			sat = 1'b1;
			return 128'sd2147483647;
		end
		if (s < -128'sd2147483648) begin
			sat = 1'b1;
			return -128'sd2147483648;
		end
		return s;
	endfunction

	function automatic gcts_pkg::result_t predict_exit(input gcts_pkg::item_t it);
		logic signed [127:0] val, act, y, v, a, ms, y0, e, am, vm, d, s, q, best, t;
		logic signed [127:0] nums[2];
		bit never, sat, found, best_sat, qs;
		gcts_pkg::result_t r;
		val = it.exit_value; act = it.activation_time; y = it.position_y;
		v = it.velocity_y; a = it.acceleration_y; ms = it.motion_start;
		e = eps_model;
		never = 0; sat = 0; found = 0; best = 0; best_sat = 0; t = 0;
		if (it.exit_kind == KIND_TIME) begin
			t = clamp_sum(act + val, sat);
		end else begin
			y0 = y - val;
			am = a < 0 ? -a : a;
			vm = v < 0 ? -v : v;
			if (am < e || a == 0) begin
				// linear root, or a body at rest
				if (vm < e || v == 0) never = 1;
				else begin
					q = $signed(div_clamp(-y0, v, qs));
					if (q > e) begin
						found = 1; best = q; best_sat = qs;
					end else never = 1;
				end
			end else begin
				d = v * v - 2 * a * y0;
				if (d < 0) never = 1;
				else begin
					s = isqrt_floor(d);
					nums[0] = -v + s;
					nums[1] = -v - s;
					// keep the smallest root past epsilon
					for (int k = 0; k < 2; k++) begin
						q = $signed(div_clamp(nums[k], a, qs));
						if (q > e && (!found || q < best)) begin
							found = 1; best = q; best_sat = qs;
						end
					end
					if (!found) never = 1;
				end
			end
			if (found) begin
				sat = best_sat;
				t = clamp_sum(ms + best, sat);
			end
		end
		if (never) begin
			t = 0; sat = 0;
		end
		r.exit_time = t[31:0];
		r.never_hits = never;
		r.saturated = sat;
		return r;
	endfunction

	// compare each result beat with the oldest expectation
	initial begin
		gcts_pkg::result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (exit_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat %p", result);
				end else begin
					want = exit_q.pop_front();
					if (result.exit_time !== want.exit_time
							|| result.never_hits !== want.never_hits
							|| result.saturated !== want.saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected t=%h n=%b s=%b got t=%h n=%b s=%b",
								want.exit_time, want.never_hits, want.saturated,
								result.exit_time, result.never_hits, result.saturated);
					end
				end
			end
		end
	end

	// random receiver stalls, plus a long hold-off on request
	initial begin
		int gap;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_results = 0;
				result_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
					: $urandom_range(1, 3);
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				result_stall <= 1'b0;
			end else if ($urandom_range(0, 40) == 0) begin
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	task automatic send_item(input gcts_pkg::item_t it, input bit gaps);
		int gap;
		if (gaps && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(1, 3);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		exit_q.insert(exit_q.size(), predict_exit(it));
		do @(posedge clk); while (item_stall);
	endtask

	task automatic stop_items;
		item_valid <= 1'b0;
	endtask

	task automatic drain;
		stop_items();
		while (exit_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [15:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {gcts_pkg::REG_EPSILON, 2'b00};
		pwdata <= {16'($urandom_range(0, 65535)), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		eps_model = value;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_word;
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 16);
			3: return -$urandom_range(0, 16);
			4: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			default: return $urandom;
		endcase
	endfunction

	// realistic trajectory: small values, gravity down, ground below
	function automatic gcts_pkg::item_t rand_flight;
		gcts_pkg::item_t it;
		it.exit_kind = KIND_GROUND;
		it.exit_value = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		it.activation_time = $urandom;
		it.position_y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0010_0000;
		it.velocity_y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
		it.acceleration_y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9)
			: -$signed($urandom_range(1, 32'h00A0_0000));
		it.motion_start = $signed($urandom_range(0, 32'h0100_0000));
		return it;
	endfunction

	function automatic gcts_pkg::item_t make_item(input logic kind, input logic [31:0] val,
			input logic [31:0] act, input logic [31:0] y, input logic [31:0] v,
			input logic [31:0] a, input logic [31:0] ms);
		gcts_pkg::item_t it;
		it.exit_kind = kind; it.exit_value = val; it.activation_time = act;
		it.position_y = y; it.velocity_y = v; it.acceleration_y = a;
		it.motion_start = ms;
		return it;
	endfunction

	task automatic test_directed;
		// time offsets: plain, overflow both ways
		send_item(make_item(KIND_TIME, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0), 0);
		send_item(make_item(KIND_TIME, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 2, 3, 4), 0);
		send_item(make_item(KIND_TIME, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0), 0);
		send_item(make_item(KIND_TIME, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0), 0);
		// at rest, linear root ahead and behind
		send_item(make_item(KIND_GROUND, 0, 0, 32'h0001_0000, 0, 0, 0), 0);
		send_item(make_item(KIND_GROUND, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 0, 5), 0);
		send_item(make_item(KIND_GROUND, 0, 0, 32'h0001_0000, 32'h0001_0000, 3, 5), 0);
		send_item(make_item(KIND_GROUND, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0), 0);
		// quadratic: fall, launch from the ground, never reaching it
		send_item(make_item(KIND_GROUND, 0, 0, 32'h000A_0000, 0, 32'hFFF6_0000, 0), 0);
		send_item(make_item(KIND_GROUND, 0, 0, 0, 32'h0005_0000, 32'hFFF6_0000, 9), 0);
		send_item(make_item(KIND_GROUND, 0, 0, 32'h000A_0000, 0, 32'h000A_0000, 0), 0);
		send_item(make_item(KIND_GROUND, 32'h8000_0000, 0, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF), 0);
		send_item(make_item(KIND_GROUND, 32'h7FFF_FFFF, 0, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 0);
		send_item(make_item(KIND_GROUND, 0, 0, 1, 32'h7FFF_FFFF, 8, 32'h7FFF_0000), 0);
		send_item(make_item(KIND_GROUND, 0, 0, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0), 0);
		drain();
	endtask

	task automatic test_random(input int count);
		gcts_pkg::item_t it;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 7) it = rand_flight();
			else it = make_item(1'($urandom_range(0, 1)), rand_word(), rand_word(),
				rand_word(), rand_word(), rand_word(), rand_word());
			send_item(it, 1);
		end
		drain();
	endtask

	task automatic test_backpressure;
		hold_results = 1;
		for (int i = 0; i < 250; i++) send_item(rand_flight(), 0);
		drain();
	endtask

	task automatic test_epsilon_settings;
		write_epsilon(16'd0);
		test_random(150);
		write_epsilon(16'hFFFF);
		test_random(150);
		write_epsilon(16'($urandom_range(1, 2000)));
		test_random(150);
		write_epsilon(16'd7);
		test_random(150);
	endtask

	initial begin
		mismatches = 0;
		hold_results = 0;
		eps_model = gcts_pkg::EPS_RESET;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200);
		test_backpressure();
		test_epsilon_settings();
		if (mismatches == 0 && exit_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/gcts_pkg.sv
src/gcts_front.sv
src/gcts_sqrt.sv
src/gcts_div.sv
src/ground_contact_time_solver.sv
sim/ground_contact_time_solver_tb.sv
